// ----- src/assert_macros.svh -----
// assertion macros included by the encoder top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, off while in reset
`define CANSFE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// next-cycle implication, off while in reset
`define CANSFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cansfe_pkg.sv -----
// types, constants and crc functions of the can serial frame encoder
package cansfe_pkg;

    localparam int ID_W   = 32;
    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;

    localparam logic [7:0]  SYNC_BYTE    = 8'hAA;
    localparam logic [7:0]  HDR_BYTE1    = 8'h01;
    localparam logic [7:0]  HDR_BYTE2    = 8'hFF;
    localparam logic [7:0]  HDR_BYTE3    = 8'h10;
    localparam logic [7:0]  LEN_OFFSET   = 8'h08;
    localparam logic [7:0]  BODY_START   = 8'h01;
    localparam logic [7:0]  CMD_NORMAL   = 8'h01;
    localparam logic [7:0]  CMD_SPECIAL  = 8'h02;
    localparam logic [31:0] SPECIAL_ID   = 32'h0000_0041;
    localparam logic [7:0]  CRC8_POLY    = 8'h07;
    localparam logic [7:0]  CRC8_INIT    = 8'hFF;
    localparam logic [15:0] CRC16_POLY   = 16'h1021;
    localparam logic [15:0] CRC16_INIT   = 16'hFFFF;

    typedef struct packed {
        logic [ID_W-1:0]   can_id;
        logic [LEN_W-1:0]  data_len;
        logic [DATA_W-1:0] data_bytes;
    } t_req;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        last_byte;
        logic [7:0]  hdr_crc;
        logic [15:0] body_crc;
    } t_gen_out;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC8_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- src/cansfe_req_if.sv -----
// request channel: can transmit request with valid/ready handshake
interface cansfe_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] can_id;
    logic [3:0]  data_len;
    logic [63:0] data_bytes;

    modport source (output valid, output can_id, output data_len, output data_bytes,
                    input ready);
    modport sink   (input valid, input can_id, input data_len, input data_bytes,
                    output ready);
endinterface

// ----- src/cansfe_byte_if.sv -----
// byte channel: serial frame bytes with valid/ready handshake
interface cansfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ----- src/cansfe_byte_gen.sv -----
// frame byte selection and running crc update for one byte position
module cansfe_byte_gen #(
    parameter int FRAME_BYTES = 26
) (
    input  cansfe_pkg::t_req                       i_req,
    input  logic [$clog2(FRAME_BYTES)-1:0]         i_pos,
    input  logic [7:0]                             i_hdr_crc,
    input  logic [15:0]                            i_body_crc,
    output cansfe_pkg::t_gen_out                   o_res
);
    import cansfe_pkg::*;

    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    logic [POS_W-1:0] crc_at;
    logic [POS_W-1:0] body_idx;
    logic [7:0]       hdr_b;
    logic [7:0]       body_b;
    logic [1:0]       id_idx;
    logic [2:0]       data_idx;

    assign crc_at   = POS_W'(16) + POS_W'(i_req.data_len);
    assign body_idx = i_pos - POS_W'(8);
    assign id_idx   = 2'(body_idx - POS_W'(2));
    assign data_idx = 3'(body_idx - POS_W'(8));

    always_comb begin
        case (i_pos[2:0])
            3'd0:    hdr_b = SYNC_BYTE;
            3'd1:    hdr_b = HDR_BYTE1;
            3'd2:    hdr_b = HDR_BYTE2;
            3'd3:    hdr_b = HDR_BYTE3;
            3'd5:    hdr_b = 8'(i_req.data_len) + LEN_OFFSET;
            default: hdr_b = 8'h00;
        endcase
    end

    always_comb begin
        if (body_idx == POS_W'(0)) begin
            body_b = BODY_START;
        end else if (body_idx == POS_W'(1)) begin
            body_b = (i_req.can_id == SPECIAL_ID) ? CMD_SPECIAL : CMD_NORMAL;
        end else if (body_idx < POS_W'(6)) begin
            body_b = i_req.can_id[8*id_idx +: 8];
        end else if (body_idx == POS_W'(6)) begin
            body_b = 8'h00;
        end else if (body_idx == POS_W'(7)) begin
            body_b = 8'(i_req.data_len);
        end else begin
            body_b = i_req.data_bytes[8*data_idx +: 8];
        end
    end

    always_comb begin
        o_res.hdr_crc   = i_hdr_crc;
        o_res.body_crc  = i_body_crc;
        o_res.last_byte = (i_pos == LAST_POS);
        if (i_pos < POS_W'(7)) begin
            o_res.frame_byte = hdr_b;
            o_res.hdr_crc    = crc8_update(i_hdr_crc, hdr_b);
        end else if (i_pos == POS_W'(7)) begin
            o_res.frame_byte = i_hdr_crc;
        end else if (i_pos < crc_at) begin
            o_res.frame_byte = body_b;
            o_res.body_crc   = crc16_update(i_body_crc, body_b);
        end else if (i_pos == crc_at) begin
            o_res.frame_byte = i_body_crc[7:0];
        end else if (i_pos == crc_at + POS_W'(1)) begin
            o_res.frame_byte = i_body_crc[15:8];
        end else begin
            o_res.frame_byte = 8'h00;
        end
    end

endmodule

// ----- src/can_serial_frame_encoder_unit.sv -----
// top level of the can serial frame encoder
//
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    can_id[31:0], data_len[3:0], data_bytes[63:0]
//  o_byte    out  valid/ready    frame_byte[7:0], last_byte
//
//  one request gives FRAME_BYTES bytes, one per cycle from the byte register while o_byte does not stall
//  a new request is not taken before the single byte position counter reaches the last byte of the frame
//  the next request is taken in the cycle the last byte of the frame is generated
//  a stall on o_byte holds the byte register and the position counter
//  synchronous active-low reset empties both registers
`include "assert_macros.svh"

module can_serial_frame_encoder_unit #(
    parameter int FRAME_BYTES    = 26,
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cansfe_req_if.sink           i_req,
    cansfe_byte_if.source        o_byte
);
    import cansfe_pkg::*;

    localparam int POS_W = $clog2(FRAME_BYTES);

    logic             r_busy;
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_hdr_crc;
    logic [15:0]      r_body_crc;
    t_req             r_req;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    t_gen_out         gen_res;
    logic             adv;
    logic             accept;
    logic [LEN_W-1:0] n_len;

    assign adv    = r_busy && (!r_out_valid || o_byte.ready);
    assign accept = i_req.valid && i_req.ready;
    assign n_len  = (i_req.data_len > LEN_W'(MAX_DATA_BYTES)) ? LEN_W'(MAX_DATA_BYTES)
                                                              : i_req.data_len;

    assign i_req.ready       = !r_busy || (adv && gen_res.last_byte);
    assign o_byte.valid      = r_out_valid;
    assign o_byte.frame_byte = r_out_byte;
    assign o_byte.last_byte  = r_out_last;

    cansfe_byte_gen #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_byte_gen (
        .i_req      (r_req),
        .i_pos      (r_pos),
        .i_hdr_crc  (r_hdr_crc),
        .i_body_crc (r_body_crc),
        .o_res      (gen_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_hdr_crc   <= CRC8_INIT;
            r_body_crc  <= CRC16_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_byte.ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_busy     <= 1'b1;
                r_pos      <= '0;
                r_hdr_crc  <= CRC8_INIT;
                r_body_crc <= CRC16_INIT;
            end else if (adv) begin
                r_hdr_crc  <= gen_res.hdr_crc;
                r_body_crc <= gen_res.body_crc;
                if (gen_res.last_byte) begin
                    r_pos  <= '0;
                    r_busy <= 1'b0;
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte <= gen_res.frame_byte;
            r_out_last <= gen_res.last_byte;
        end
        if (accept) begin
            r_req.can_id     <= i_req.can_id;
            r_req.data_len   <= n_len;
            r_req.data_bytes <= i_req.data_bytes;
        end
    end

    `CANSFE_ASSERT(a_idle_pos_zero, !r_busy |-> (r_pos == '0), "position not cleared when idle")
    `CANSFE_ASSERT(a_last_wraps, (r_out_valid && r_out_last) |-> (r_pos == '0), "position not wrapped after last byte")
    `CANSFE_ASSERT_NEXT(a_frame_ends, (adv && gen_res.last_byte && !accept), !r_busy, "frame did not end after last byte")
    `CANSFE_ASSERT_NEXT(a_accept_starts, accept, (r_busy && r_pos == '0), "request did not start a frame")

endmodule
